FILE: hdl/lzw_compressor_12bit_unit_assert.svh
// Assertion macros for the LZW compressor block.
// Taken in by `include from the files that carry concurrent assertions.
`ifndef LZW_COMPRESSOR_12BIT_UNIT_ASSERT_SVH
`define LZW_COMPRESSOR_12BIT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LZW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lzw assertion failed");
`define LZW_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("lzw forbidden condition");
`else
`define LZW_ASSERT(lbl, clk, rstn, prop)
`define LZW_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: hdl/lzw_pkg.sv
// Shared types for the LZW compressor: controller states, phases and the
// command / status structs between controller and datapath. No dependencies.
package lzw_pkg;

  localparam int unsigned CNT_W = 5;

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_HASH, ST_MOD, ST_RD, ST_CHK, ST_LOAD, ST_BYTE
  } state_e;

  typedef enum logic [1:0] {
    PH_MISS, PH_CUR, PH_END, PH_ZERO
  } phase_e;

  typedef enum logic [1:0] {
    SEL_CUR, SEL_END, SEL_ZERO
  } code_sel_e;

  typedef struct packed {
    logic      sweep_wr;
    logic      idx_clr;
    logic      load_in;
    logic      set_cur_byte;
    logic      hash_ld;
    logic      hv_sub;
    logic      probe_start;
    logic      probe_step;
    logic      dict_wr;
    logic      cur_from_hit;
    logic      pack_load;
    code_sel_e code_sel;
    logic      emit;
    logic      tag_last;
    logic      tag_end;
    logic      msg_clear;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic have;
    logic last;
    logic hv_ge;
    logic slot_empty;
    logic slot_match;
    logic probe_exh;
    logic dict_room;
    logic out_free;
    logic byte_last;
  } sts_t;

endpackage

FILE: hdl/lzw_ctrl.sv
// Controller state machine of the LZW compressor: sequences clearing,
// hashing, probing and code packing. Depends on lzw_pkg.
module lzw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_tlast_i,
  output logic          s_tready_o,
  input  lzw_pkg::sts_t sts_i,
  output lzw_pkg::cmd_t cmd_o
);

  lzw_pkg::state_e state_q, state_d;
  lzw_pkg::phase_e phase_q, phase_d;
  logic            final_q, final_d;
  logic            accept;

  assign s_tready_o = (state_q == lzw_pkg::ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzw_pkg::ST_SWEEP;
      phase_q <= lzw_pkg::PH_MISS;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      final_q <= final_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    final_d = final_q;
    cmd_o   = '0;
    cmd_o.code_sel = lzw_pkg::SEL_CUR;
    unique case (state_q)
      lzw_pkg::ST_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_IDLE: begin
        cmd_o.load_in = accept;
        if (accept) begin
          if (sts_i.have) begin
            state_d = lzw_pkg::ST_HASH;
          end else if (s_tlast_i) begin
            phase_d = lzw_pkg::PH_CUR;
            state_d = lzw_pkg::ST_LOAD;
          end
        end
      end
      lzw_pkg::ST_HASH: begin
        cmd_o.hash_ld = 1'b1;
        state_d = lzw_pkg::ST_MOD;
      end
      lzw_pkg::ST_MOD: begin
        // reduce the start slot below the table size, one subtract a cycle
        if (sts_i.hv_ge) begin
          cmd_o.hv_sub = 1'b1;
        end else begin
          cmd_o.probe_start = 1'b1;
          state_d = lzw_pkg::ST_RD;
        end
      end
      lzw_pkg::ST_RD: begin
        state_d = lzw_pkg::ST_CHK;
      end
      lzw_pkg::ST_CHK: begin
        if (sts_i.slot_empty) begin
          cmd_o.dict_wr = sts_i.dict_room;
          phase_d = lzw_pkg::PH_MISS;
          state_d = lzw_pkg::ST_LOAD;
        end else if (sts_i.slot_match) begin
          cmd_o.cur_from_hit = 1'b1;
          if (sts_i.last) begin
            phase_d = lzw_pkg::PH_CUR;
            state_d = lzw_pkg::ST_LOAD;
          end else begin
            state_d = lzw_pkg::ST_IDLE;
          end
        end else if (sts_i.probe_exh) begin
          phase_d = lzw_pkg::PH_MISS;
          state_d = lzw_pkg::ST_LOAD;
        end else begin
          cmd_o.probe_step = 1'b1;
          state_d = lzw_pkg::ST_RD;
        end
      end
      lzw_pkg::ST_LOAD: begin
        cmd_o.pack_load = 1'b1;
        case (phase_q)
          lzw_pkg::PH_END:  cmd_o.code_sel = lzw_pkg::SEL_END;
          lzw_pkg::PH_ZERO: cmd_o.code_sel = lzw_pkg::SEL_ZERO;
          default:          cmd_o.code_sel = lzw_pkg::SEL_CUR;
        endcase
        cmd_o.set_cur_byte = (phase_q == lzw_pkg::PH_MISS);
        final_d = ((phase_q == lzw_pkg::PH_MISS) && !sts_i.last) ||
                  (phase_q == lzw_pkg::PH_ZERO);
        state_d = lzw_pkg::ST_BYTE;
      end
      lzw_pkg::ST_BYTE: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.tag_last = final_q && sts_i.byte_last;
          cmd_o.tag_end  = (phase_q == lzw_pkg::PH_ZERO) && sts_i.byte_last;
          if (sts_i.byte_last) begin
            unique case (phase_q)
              lzw_pkg::PH_MISS: begin
                if (sts_i.last) begin
                  phase_d = lzw_pkg::PH_CUR;
                  state_d = lzw_pkg::ST_LOAD;
                end else begin
                  state_d = lzw_pkg::ST_IDLE;
                end
              end
              lzw_pkg::PH_CUR: begin
                phase_d = lzw_pkg::PH_END;
                state_d = lzw_pkg::ST_LOAD;
              end
              lzw_pkg::PH_END: begin
                phase_d = lzw_pkg::PH_ZERO;
                state_d = lzw_pkg::ST_LOAD;
              end
              lzw_pkg::PH_ZERO: begin
                cmd_o.msg_clear = 1'b1;
                cmd_o.idx_clr   = 1'b1;
                state_d = lzw_pkg::ST_SWEEP;
              end
              default: state_d = lzw_pkg::ST_IDLE;
            endcase
          end
        end
      end
      default: state_d = lzw_pkg::ST_SWEEP;
    endcase
  end

endmodule

FILE: hdl/lzw_dpath.sv
// Datapath of the LZW compressor: dictionary memory, hash and probe
// arithmetic, bit packer and output register. Depends on lzw_pkg.
`include "lzw_compressor_12bit_unit_assert.svh"
module lzw_dpath #(
  parameter int unsigned CODE_WIDTH = 12,
  parameter int unsigned HASH_SIZE  = 5021
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lzw_pkg::cmd_t cmd_i,
  output lzw_pkg::sts_t sts_o,
  input  logic [7:0]    s_tdata_i,
  input  logic          s_tlast_i,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [7:0]    m_tdata_o,
  output logic          m_tlast_o,
  output logic          m_tuser_o
);

  localparam int unsigned IW  = $clog2(HASH_SIZE);
  localparam int unsigned MW  = 2 * CODE_WIDTH + 9;
  localparam int unsigned PW  = CODE_WIDTH + 7;
  localparam int unsigned CW1 = CODE_WIDTH + 1;
  localparam logic [16:0]       HS17     = 17'(HASH_SIZE);
  localparam logic [IW:0]       HSX      = (IW + 1)'(HASH_SIZE);
  localparam logic [IW-1:0]     IDX_LAST = IW'(HASH_SIZE - 1);
  localparam logic [CW1-1:0]    TOP_CODE = CW1'((1 << CODE_WIDTH) - 2);
  localparam logic [CW1-1:0]    FIRST_CODE = CW1'(256);
  localparam logic [lzw_pkg::CNT_W-1:0] CODE_CNT = lzw_pkg::CNT_W'(CODE_WIDTH);

  logic [MW-1:0]         mem [HASH_SIZE];
  logic [MW-1:0]         rd_q;
  logic [MW-1:0]         wdata;
  logic [IW-1:0]         idx_q, off_q, n_q, start;
  logic [CODE_WIDTH-1:0] hv_q, cur_q, code;
  logic [7:0]            byte_q;
  logic                  last_q, have_q;
  logic [CW1-1:0]        nfree_q;
  logic [PW-1:0]         acc_q;
  logic [lzw_pkg::CNT_W-1:0] cnt_q, shamt;
  logic [16:0]           hv_ext;
  logic [IW:0]           wrap;
  logic [7:0]            mask8;
  logic [6:0]            pend;
  logic [PW-1:0]         acc_sh;
  logic                  ov_q, olast_q, oend_q;
  logic [7:0]            obyte_q;

  // dictionary memory: {valid, code, prefix, byte}
  assign wdata = cmd_i.sweep_wr ? '0 : {1'b1, nfree_q[CODE_WIDTH-1:0], cur_q, byte_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_wr || cmd_i.dict_wr) begin
      mem[idx_q] <= wdata;
    end
    rd_q <= mem[idx_q];
  end

  assign hv_ext = 17'(hv_q);
  assign start  = hv_ext[IW-1:0];
  assign wrap   = {1'b0, idx_q} + (HSX - {1'b0, off_q});

  always_comb begin
    case (cmd_i.code_sel)
      lzw_pkg::SEL_END:  code = '1;
      lzw_pkg::SEL_ZERO: code = '0;
      default:           code = cur_q;
    endcase
  end

  assign mask8  = (8'(1) << cnt_q[2:0]) - 8'(1);
  assign pend   = acc_q[6:0] & mask8[6:0];
  assign shamt  = cnt_q - lzw_pkg::CNT_W'(8);
  assign acc_sh = acc_q >> shamt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      have_q  <= 1'b0;
      cur_q   <= '0;
      nfree_q <= FIRST_CODE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.sweep_wr) begin
        idx_q <= idx_q + IW'(1);
      end else if (cmd_i.probe_start) begin
        idx_q <= start;
      end else if (cmd_i.probe_step) begin
        idx_q <= (idx_q >= off_q) ? (idx_q - off_q) : wrap[IW-1:0];
      end
      if (cmd_i.load_in && !have_q) begin
        have_q <= 1'b1;
        cur_q  <= CODE_WIDTH'(s_tdata_i);
      end else if (cmd_i.set_cur_byte) begin
        cur_q <= CODE_WIDTH'(byte_q);
      end else if (cmd_i.cur_from_hit) begin
        cur_q <= rd_q[2*CODE_WIDTH+7 -: CODE_WIDTH];
      end
      if (cmd_i.dict_wr) begin
        nfree_q <= nfree_q + CW1'(1);
      end
      if (cmd_i.msg_clear) begin
        cnt_q <= '0;
      end else if (cmd_i.pack_load) begin
        cnt_q <= cnt_q + CODE_CNT;
      end else if (cmd_i.emit) begin
        cnt_q <= shamt;
      end
      if (cmd_i.msg_clear) begin
        have_q  <= 1'b0;
        cur_q   <= '0;
        nfree_q <= FIRST_CODE;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q <= s_tdata_i;
      last_q <= s_tlast_i;
    end
    if (cmd_i.hash_ld) begin
      hv_q <= {byte_q, {(CODE_WIDTH - 8){1'b0}}} ^ cur_q;
    end else if (cmd_i.hv_sub) begin
      hv_q <= CODE_WIDTH'(hv_ext - HS17);
    end
    if (cmd_i.probe_start) begin
      off_q <= (start == '0) ? IW'(1) : IW'(HSX - (IW + 1)'(start));
      n_q   <= '0;
    end else if (cmd_i.probe_step) begin
      n_q <= n_q + IW'(1);
    end
    if (cmd_i.pack_load) begin
      acc_q <= {pend, code};
    end
    if (cmd_i.emit) begin
      obyte_q <= acc_sh[7:0];
      olast_q <= cmd_i.tag_last;
      oend_q  <= cmd_i.tag_end;
    end
  end

  assign sts_o.sweep_done = (idx_q == IDX_LAST);
  assign sts_o.have       = have_q;
  assign sts_o.last       = last_q;
  assign sts_o.hv_ge      = (hv_ext >= HS17);
  assign sts_o.slot_empty = !rd_q[MW-1];
  assign sts_o.slot_match = (rd_q[CODE_WIDTH+7:8] == cur_q) && (rd_q[7:0] == byte_q);
  assign sts_o.probe_exh  = (n_q == IDX_LAST);
  assign sts_o.dict_room  = (nfree_q <= TOP_CODE);
  assign sts_o.out_free   = !ov_q || m_tready_i;
  assign sts_o.byte_last  = (cnt_q < lzw_pkg::CNT_W'(16));

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = obyte_q;
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = oend_q;

  `LZW_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_i.emit && ov_q && !m_tready_i)
  `LZW_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= lzw_pkg::CNT_W'(CODE_WIDTH + 7))
  `LZW_ASSERT(a_end_clears, clk_i, rst_ni, cmd_i.emit && cmd_i.tag_end |=> nfree_q == FIRST_CODE && cnt_q == '0)

endmodule

FILE: hdl/lzw_compressor_12bit_unit.sv
// LZW compressor: one raw byte per input word, packed 12-bit codes out.
// First byte of a message: only taken in. A byte that hits on its first probe passes accept,
// hash, reduce, read and check; each further probe repeats read and check, and reduce repeats
// while the slot is not below HASH_SIZE. A miss adds a code load and its output words, each
// sent from the byte state. A last byte adds three more code loads. Output stalls hold it.
// After reset and each message a clearing pass over all HASH_SIZE slots holds s_tready_o low.
module lzw_compressor_12bit_unit #(
  parameter int unsigned CODE_WIDTH = 12,
  parameter int unsigned HASH_SIZE  = 5021
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] data_byte
  input  logic       s_tlast_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] out_byte
  output logic       m_tlast_o,
  output logic [0:0] m_tuser_o    // [0] stream_end
);

  lzw_pkg::cmd_t cmd;
  lzw_pkg::sts_t sts;

  lzw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tlast_i  (s_tlast_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzw_dpath #(
    .CODE_WIDTH (CODE_WIDTH),
    .HASH_SIZE  (HASH_SIZE)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o[0])
  );

endmodule
